// File: rtl/wvh_pkg.sv
// ----------------------------------------------------------------------------
// wvh_pkg
// Shared constants and codes for the word vocabulary hash table.
// ----------------------------------------------------------------------------
package wvh_pkg;

  localparam int SLOTS_DEF          = 4096;
  localparam int MAX_WORD_BYTES_DEF = 16;

  localparam int ID_W  = 13;
  localparam int POS_W = 12;
  localparam int ST_W  = 3;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [ID_W-1:0] NO_ID = {ID_W{1'b1}};

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_INSERT = 2'd2;
  localparam logic [1:0] KIND_GET    = 2'd3;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_TOO_LONG = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
  localparam logic [ST_W-1:0] ST_BAD_POS  = 3'd3;
  localparam logic [ST_W-1:0] ST_DUP      = 3'd4;

endpackage

// File: rtl/wvh_asm.sv
// ----------------------------------------------------------------------------
// wvh_asm
// Word assembly buffer with running FNV-1a hash and overlong flag.
// ----------------------------------------------------------------------------
module wvh_asm #(
  parameter int MAX_WORD_BYTES = wvh_pkg::MAX_WORD_BYTES_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     push,
  input  logic [7:0]                               push_byte,
  input  logic                                     clear,
  output logic [31:0]                              hash,
  output logic [$clog2(MAX_WORD_BYTES+1)-1:0]      len,
  output logic                                     too_long,
  output logic [MAX_WORD_BYTES*8-1:0]              bytes
);
  import wvh_pkg::*;

  localparam int LW  = $clog2(MAX_WORD_BYTES + 1);
  localparam int IXW = $clog2(MAX_WORD_BYTES);

  logic [31:0]                         hash_r;
  logic [LW-1:0]                       len_r;
  logic                                too_long_r;
  logic [MAX_WORD_BYTES-1:0][7:0]      bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r     <= FNV_BASIS;
      len_r      <= '0;
      too_long_r <= 1'b0;
    end else if (clear) begin
      hash_r     <= FNV_BASIS;
      len_r      <= '0;
      too_long_r <= 1'b0;
    end else if (push) begin
      hash_r <= (hash_r ^ {24'd0, push_byte}) * FNV_PRIME;
      if (len_r < LW'(MAX_WORD_BYTES)) begin
        len_r <= len_r + 1'b1;
      end else begin
        too_long_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !clear && (len_r < LW'(MAX_WORD_BYTES))) begin
      bytes_r[len_r[IXW-1:0]] <= push_byte;
    end
  end

  assign hash     = hash_r;
  assign len      = len_r;
  assign too_long = too_long_r;
  assign bytes    = bytes_r;

endmodule

// File: rtl/wvh_mod.sv
// ----------------------------------------------------------------------------
// wvh_mod
// Remainder of a 32-bit hash by the slot count by reciprocal multiplication.
// ----------------------------------------------------------------------------
module wvh_mod #(
  parameter int SLOTS = wvh_pkg::SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [31:0]               value,
  output logic                      done,
  output logic [$clog2(SLOTS)-1:0]  rem
);
  import wvh_pkg::*;

  localparam int SAW = $clog2(SLOTS);
  localparam int SH  = 32 + SAW;
  // floor(2^SH / SLOTS): the quotient estimate is exact or one low
  localparam logic [33:0] RECIP = 34'((64'd1 << SH) / 64'(SLOTS));

  logic [31:0]    val_r;
  logic [65:0]    prod_r;
  logic [SAW:0]   diff_r;
  logic [SAW-1:0] rem_r;
  logic           v1_r;
  logic           v2_r;
  logic           done_r;
  logic [31:0]    quo;
  logic [31:0]    diff;

  always_comb begin
    quo  = 32'(prod_r >> SH);
    diff = val_r - quo * 32'(SLOTS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= value;
      prod_r <= value * RECIP;
    end
    if (v1_r) begin
      diff_r <= diff[SAW:0];
    end
    if (v2_r) begin
      rem_r <= (diff_r >= (SAW+1)'(SLOTS)) ? SAW'(diff_r - (SAW+1)'(SLOTS)) :
                                             diff_r[SAW-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: rtl/word_vocabulary_hash_table.sv
// ----------------------------------------------------------------------------
// word_vocabulary_hash_table
// Word vocabulary: FNV-1a hash, linear-probing slot memory, word store memory.
// ----------------------------------------------------------------------------
// a byte without last mark is buffered; get word reads the row, then one byte per item
// a completing byte: start, hash remainder, read + check + compare per occupied slot,
//   read + check at an empty one, commit when a word is stored, emit; an overlong word
//   or bad position goes from start to emit; insert adds a renumber sweep of all slots
//   and a word shift; one transaction at a time; a stalled result holds the emit state
// after reset a clearing pass empties the slot memory, in_stall high
// ----------------------------------------------------------------------------
module word_vocabulary_hash_table #(
  parameter int SLOTS          = wvh_pkg::SLOTS_DEF,
  parameter int MAX_WORD_BYTES = wvh_pkg::MAX_WORD_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_kind,
  input  logic [7:0]                  in_word_byte,
  input  logic                        in_word_last,
  input  logic [wvh_pkg::POS_W-1:0]   in_position,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [wvh_pkg::ID_W-1:0] out_result_id,
  output logic [wvh_pkg::ST_W-1:0]    out_status,
  output logic [7:0]                  out_byte,
  output logic                        out_last,
  output logic [wvh_pkg::ID_W-1:0]    out_vocab_count
);
  import wvh_pkg::*;

  localparam int SAW = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int LW  = $clog2(MAX_WORD_BYTES + 1);
  localparam int IXW = $clog2(MAX_WORD_BYTES);
  localparam int BW  = MAX_WORD_BYTES * 8;
  localparam int RW  = BW + LW;
  localparam logic [SAW-1:0] LAST_SLOT = SAW'(SLOTS - 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_START, S_MOD, S_PRD, S_PCHK, S_PCMP,
    S_RN_RD, S_RN_WR, S_SH_RD, S_SH_WR, S_COMMIT, S_EMIT, S_GW
  } state_t;

  // memories
  logic [ID_W-1:0] slot_mem [SLOTS];
  logic [RW-1:0]   word_mem [SLOTS];
  logic            slot_we, word_we;
  logic [SAW-1:0]  slot_wa, slot_ra, word_wa, word_ra;
  logic [ID_W-1:0] slot_wd, slot_q;
  logic [RW-1:0]   word_wd, word_q;

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_q <= slot_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (word_we) begin
      word_mem[word_wa] <= word_wd;
    end
    word_q <= word_mem[word_ra];
  end

  // assembly and hash remainder
  logic            asm_push, asm_clr, asm_too_long;
  logic [31:0]     asm_hash;
  logic [LW-1:0]   asm_len;
  logic [BW-1:0]   asm_bytes;
  logic            mod_start, mod_done;
  logic [SAW-1:0]  mod_rem;

  wvh_asm #(.MAX_WORD_BYTES(MAX_WORD_BYTES)) u_asm (
    .clk(clk), .rst_n(rst_n), .push(asm_push), .push_byte(in_word_byte),
    .clear(asm_clr), .hash(asm_hash), .len(asm_len), .too_long(asm_too_long),
    .bytes(asm_bytes)
  );

  wvh_mod #(.SLOTS(SLOTS)) u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .value(asm_hash),
    .done(mod_done), .rem(mod_rem)
  );

  // control registers
  state_t          state_r, state_nxt;
  logic [1:0]      kind_r, kind_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [SAW-1:0]  s_r, s_nxt, n_r, n_nxt, i_r, i_nxt;
  logic [ID_W-1:0] id_r, id_nxt, res_id_r, res_id_nxt;
  logic [ST_W-1:0] res_st_r, res_st_nxt;
  logic [LW-1:0]   gw_r, gw_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [ID_W-1:0] out_id_r, out_id_nxt;
  logic [ST_W-1:0] out_st_r, out_st_nxt;
  logic [7:0]      out_byte_r, out_byte_nxt;
  logic            out_last_r, out_last_nxt;
  logic [ID_W-1:0] out_cnt_r, out_cnt_nxt;

  logic            can_emit, emit, e_last, word_match, in_pos_bad, pos_bad;
  logic [ID_W-1:0] e_id;
  logic [ST_W-1:0] e_st;
  logic [7:0]      e_byte;
  logic [LW-1:0]   row_len;
  logic [SAW-1:0]  cid;

  assign can_emit   = !out_valid_r || !out_stall;
  assign in_pos_bad = 32'(in_position) >= 32'(count_r);
  assign pos_bad    = 32'(pos_r) >= 32'(count_r);
  assign row_len    = word_q[RW-1 -: LW];
  assign cid        = (kind_r == KIND_INSERT) ? SAW'(pos_r) : SAW'(count_r);

  // masked compare of the stored row against the assembled word
  always_comb begin
    word_match = (row_len == asm_len);
    for (int k = 0; k < MAX_WORD_BYTES; k++) begin
      if ((LW'(k) < asm_len) && (word_q[k*8 +: 8] != asm_bytes[k*8 +: 8])) begin
        word_match = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    pos_nxt    = pos_r;
    count_nxt  = count_r;
    s_nxt      = s_r;
    n_nxt      = n_r;
    i_nxt      = i_r;
    id_nxt     = id_r;
    res_id_nxt = res_id_r;
    res_st_nxt = res_st_r;
    gw_nxt     = gw_r;
    slot_we    = 1'b0;
    slot_wa    = s_r;
    slot_wd    = NO_ID;
    slot_ra    = s_r;
    word_we    = 1'b0;
    word_wa    = cid;
    word_wd    = {asm_len, asm_bytes};
    word_ra    = SAW'(pos_r);
    mod_start  = 1'b0;
    asm_push   = 1'b0;
    asm_clr    = 1'b0;
    emit       = 1'b0;
    e_id       = res_id_r;
    e_st       = res_st_r;
    e_byte     = 8'd0;
    e_last     = 1'b1;

    case (state_r)
      S_CLR: begin
        slot_we = 1'b1;
        slot_wa = i_r;
        if (i_r == LAST_SLOT) begin
          i_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_kind;
          pos_nxt  = in_position;
          if (in_kind == KIND_GET) begin
            word_ra = SAW'(in_position);
            gw_nxt  = '0;
            if (in_pos_bad) begin
              res_id_nxt = NO_ID;
              res_st_nxt = ST_BAD_POS;
              state_nxt  = S_EMIT;
            end else begin
              state_nxt = S_GW;
            end
          end else begin
            asm_push = 1'b1;
            if (in_word_last) begin
              state_nxt = S_START;
            end
          end
        end
      end
      S_START: begin
        res_id_nxt = NO_ID;
        if (asm_too_long) begin
          res_st_nxt = ST_TOO_LONG;
          state_nxt  = S_EMIT;
        end else if (kind_r == KIND_INSERT && pos_bad) begin
          res_st_nxt = ST_BAD_POS;
          state_nxt  = S_EMIT;
        end else begin
          mod_start = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          s_nxt     = mod_rem;
          n_nxt     = '0;
          state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        if (slot_q[ID_W-1]) begin
          // empty slot ends the probe
          res_id_nxt = NO_ID;
          res_st_nxt = ST_OK;
          state_nxt  = S_EMIT;
          if (kind_r != KIND_LOOKUP) begin
            if (32'(count_r) < 32'(SLOTS)) begin
              i_nxt     = '0;
              state_nxt = (kind_r == KIND_INSERT) ? S_RN_RD : S_COMMIT;
            end else begin
              res_st_nxt = ST_FULL;
            end
          end
        end else begin
          id_nxt    = slot_q;
          word_ra   = SAW'(slot_q);
          state_nxt = S_PCMP;
        end
      end
      S_PCMP: begin
        if (word_match) begin
          res_id_nxt = id_r;
          res_st_nxt = (kind_r == KIND_INSERT) ? ST_DUP : ST_OK;
          state_nxt  = S_EMIT;
        end else if (n_r == LAST_SLOT) begin
          res_id_nxt = NO_ID;
          res_st_nxt = (kind_r == KIND_LOOKUP) ? ST_OK : ST_FULL;
          state_nxt  = S_EMIT;
        end else begin
          n_nxt     = n_r + 1'b1;
          s_nxt     = (s_r == LAST_SLOT) ? '0 : s_r + 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_RN_RD: begin
        slot_ra   = i_r;
        state_nxt = S_RN_WR;
      end
      S_RN_WR: begin
        // bump every id at or above the insert position
        if (!slot_q[ID_W-1] && (32'(slot_q) >= 32'(pos_r))) begin
          slot_we = 1'b1;
          slot_wa = i_r;
          slot_wd = slot_q + 1'b1;
        end
        if (i_r == LAST_SLOT) begin
          i_nxt     = SAW'(count_r - 1'b1);
          state_nxt = S_SH_RD;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_RN_RD;
        end
      end
      S_SH_RD: begin
        word_ra   = i_r;
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        word_we = 1'b1;
        word_wa = i_r + 1'b1;
        word_wd = word_q;
        if (i_r == SAW'(pos_r)) begin
          state_nxt = S_COMMIT;
        end else begin
          i_nxt     = i_r - 1'b1;
          state_nxt = S_SH_RD;
        end
      end
      S_COMMIT: begin
        word_we    = 1'b1;
        slot_we    = 1'b1;
        slot_wd    = ID_W'(cid);
        count_nxt  = count_r + 1'b1;
        res_id_nxt = ID_W'(cid);
        res_st_nxt = ST_OK;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (can_emit) begin
          emit      = 1'b1;
          asm_clr   = (kind_r != KIND_GET);
          state_nxt = S_IDLE;
        end
      end
      S_GW: begin
        if (can_emit) begin
          emit = 1'b1;
          e_id = {1'b0, pos_r};
          e_st = ST_OK;
          if (row_len == '0 || row_len > LW'(MAX_WORD_BYTES)) begin
            state_nxt = S_IDLE;
          end else begin
            e_byte = word_q[gw_r[IXW-1:0]*8 +: 8];
            e_last = (gw_r + 1'b1 == row_len);
            if (e_last) begin
              state_nxt = S_IDLE;
            end else begin
              gw_nxt = gw_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_id_nxt    = out_id_r;
    out_st_nxt    = out_st_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_cnt_nxt   = out_cnt_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_id_nxt    = e_id;
      out_st_nxt    = e_st;
      out_byte_nxt  = e_byte;
      out_last_nxt  = e_last;
      out_cnt_nxt   = ID_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      i_r         <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r     <= kind_nxt;
    pos_r      <= pos_nxt;
    s_r        <= s_nxt;
    n_r        <= n_nxt;
    id_r       <= id_nxt;
    res_id_r   <= res_id_nxt;
    res_st_r   <= res_st_nxt;
    gw_r       <= gw_nxt;
    out_id_r   <= out_id_nxt;
    out_st_r   <= out_st_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_result_id   = out_id_r;
  assign out_status      = out_st_r;
  assign out_byte        = out_byte_r;
  assign out_last        = out_last_r;
  assign out_vocab_count = out_cnt_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(SLOTS))
    else $error("word count beyond slot count");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (count_r == $past(count_r) + 1'b1))
    else $error("word count moved by other than one");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (!out_valid_r && count_r == '0))
    else $error("activity during clearing pass");

endmodule
